@@ sv/s5x_pkg.sv @@
package s5x_pkg;

	// One beat of the table body stream
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} s5x_in_beat_t;

	// One beat of the result stream
	typedef struct packed {
		logic [1:0]  status;
		logic [17:0] sleep_type_a;
		logic [17:0] sleep_type_b;
	} s5x_out_beat_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_PARSE  = 2'd2;
	localparam logic [1:0] ST_TRUNC  = 2'd3;

	localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHR_S          = 8'h53;
	localparam logic [7:0] CHR_5          = 8'h35;
	localparam logic [7:0] CHR_BACKSLASH  = 8'h5C;
	localparam logic [7:0] OP_NAME        = 8'h08;
	localparam logic [7:0] OP_PACKAGE     = 8'h12;
	localparam logic [7:0] OP_BYTE_PREFIX = 8'h0A;

endpackage

@@ sv/s5x_in_stage.sv @@
module s5x_in_stage
	import s5x_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         src_valid,
	output logic         src_ready,
	input  s5x_in_beat_t src_beat,
	input  logic         advance,
	output logic         valid_s1,
	output s5x_in_beat_t beat_s1
);

	logic vld_s1;

	// Take a new beat when empty or when the held beat leaves this cycle
	assign src_ready = !vld_s1 || advance;
	assign valid_s1  = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			beat_s1 <= src_beat;
		end
	end

endmodule

@@ sv/s5x_parser.sv @@
module s5x_parser
	import s5x_pkg::*;
#(
	parameter int SLEEP_SHIFT = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  s5x_in_beat_t  beat,
	output logic          emit,
	output s5x_out_beat_t result
);

	localparam logic [2:0] PH_SEARCH  = 3'd0;
	localparam logic [2:0] PH_OPCODE  = 3'd1;
	localparam logic [2:0] PH_PKGLEN  = 3'd2;
	localparam logic [2:0] PH_SKIP    = 3'd3;
	localparam logic [2:0] PH_A_FIRST = 3'd4;
	localparam logic [2:0] PH_A_VALUE = 3'd5;
	localparam logic [2:0] PH_B_FIRST = 3'd6;
	localparam logic [2:0] PH_B_VALUE = 3'd7;

	localparam int          HIST_DEPTH = 5;
	localparam logic [2:0]  HIST_FULL  = 3'(HIST_DEPTH);

	logic [7:0] hist_q [HIST_DEPTH];
	logic [2:0] fill_q;
	logic [2:0] phase_q;
	logic [2:0] skip_q;
	logic [7:0] type_a_q;
	logic       sent_q;

	logic [7:0] hist_d [HIST_DEPTH];
	logic [2:0] fill_d;
	logic [2:0] phase_d;
	logic [2:0] skip_d;
	logic [7:0] type_a_d;
	logic       sent_d;

	logic [7:0] c;
	logic       name_hit;
	logic       prefix_ok;

	assign c = beat.data_byte;

	assign name_hit = (fill_q >= 3'd3) && (c == CHR_UNDERSCORE) && (hist_q[0] == CHR_5)
		&& (hist_q[1] == CHR_S) && (hist_q[2] == CHR_UNDERSCORE);
	assign prefix_ok = ((fill_q >= 3'd4) && (hist_q[3] == OP_NAME))
		|| ((fill_q >= 3'd5) && (hist_q[4] == OP_NAME) && (hist_q[3] == CHR_BACKSLASH));

	always_comb begin
		hist_d   = hist_q;
		fill_d   = fill_q;
		phase_d  = phase_q;
		skip_d   = skip_q;
		type_a_d = type_a_q;
		sent_d   = sent_q;
		emit     = 1'b0;
		result   = '0;

		if (!sent_q) begin
			case (phase_q)
				PH_SEARCH: begin
					if (name_hit) begin
						if (prefix_ok) begin
							phase_d = PH_OPCODE;
						end else begin
							emit          = 1'b1;
							result.status = ST_PARSE;
						end
					end
				end
				PH_OPCODE: begin
					if (c == OP_PACKAGE) begin
						phase_d = PH_PKGLEN;
					end else begin
						emit          = 1'b1;
						result.status = ST_PARSE;
					end
				end
				PH_PKGLEN: begin
					skip_d  = {1'b0, c[7:6]} + 3'd1;
					phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					skip_d = skip_q - 3'd1;
					if (skip_q == 3'd1) begin
						phase_d = PH_A_FIRST;
					end
				end
				PH_A_FIRST: begin
					if (c == OP_BYTE_PREFIX) begin
						phase_d = PH_A_VALUE;
					end else begin
						type_a_d = c;
						phase_d  = PH_B_FIRST;
					end
				end
				PH_A_VALUE: begin
					type_a_d = c;
					phase_d  = PH_B_FIRST;
				end
				PH_B_FIRST: begin
					if (c == OP_BYTE_PREFIX) begin
						phase_d = PH_B_VALUE;
					end else begin
						emit                = 1'b1;
						result.status       = ST_OK;
						result.sleep_type_a = 18'(type_a_q) << SLEEP_SHIFT;
						result.sleep_type_b = 18'(c) << SLEEP_SHIFT;
					end
				end
				default: begin
					emit                = 1'b1;
					result.status       = ST_OK;
					result.sleep_type_a = 18'(type_a_q) << SLEEP_SHIFT;
					result.sleep_type_b = 18'(c) << SLEEP_SHIFT;
				end
			endcase

			for (int k = HIST_DEPTH - 1; k > 0; k--) begin
				hist_d[k] = hist_q[k-1];
			end
			hist_d[0] = c;
			if (fill_q < HIST_FULL) begin
				fill_d = fill_q + 3'd1;
			end
			if (emit) begin
				sent_d = 1'b1;
			end
		end

		// Close out the body and re-arm; judge by the phase this byte leaves behind
		if (beat.last_byte) begin
			if (!sent_q && !emit) begin
				emit          = 1'b1;
				result.status = (phase_d == PH_SEARCH) ? ST_ABSENT : ST_TRUNC;
			end
			for (int k = 0; k < HIST_DEPTH; k++) begin
				hist_d[k] = '0;
			end
			fill_d   = '0;
			phase_d  = PH_SEARCH;
			skip_d   = '0;
			type_a_d = '0;
			sent_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
			fill_q   <= '0;
			phase_q  <= PH_SEARCH;
			skip_q   <= '0;
			type_a_q <= '0;
			sent_q   <= 1'b0;
		end else if (step) begin
			hist_q   <= hist_d;
			fill_q   <= fill_d;
			phase_q  <= phase_d;
			skip_q   <= skip_d;
			type_a_q <= type_a_d;
			sent_q   <= sent_d;
		end
	end

endmodule

@@ sv/acpi_s5_sleep_type_extractor.sv @@
// Result path: the parser decides combinationally, and the result beat is loaded into the output
//   register on the edge that advances the deciding byte out of the input register.
// Throughput: one body byte per cycle while the output register is free or draining; while a finished
//   result waits there, the input register takes one more byte if it is empty, then stalls.
// Reset: arst_n clears the input and output valids and returns the parser to searching
//   with an empty byte history; the parser also re-arms itself after every last byte.
module acpi_s5_sleep_type_extractor
	import s5x_pkg::*;
#(
	parameter int SLEEP_SHIFT = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  s5x_in_beat_t  src_beat,
	output logic          dst_valid,
	input  logic          dst_ready,
	output s5x_out_beat_t dst_beat
);

	logic          valid_s1;
	s5x_in_beat_t  beat_s1;
	logic          advance;
	logic          emit;
	s5x_out_beat_t result;

	logic          out_valid_q;
	s5x_out_beat_t out_beat_q;

	// Advance the held byte whenever the output register is free or drains this cycle;
	// each byte yields at most one result, so this never drops one.
	assign advance = valid_s1 && (!out_valid_q || dst_ready);

	s5x_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_beat  (src_beat),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1)
	);

	s5x_parser #(
		.SLEEP_SHIFT (SLEEP_SHIFT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.emit   (emit),
		.result (result)
	);

	// Output register: load a new result, otherwise drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_beat_q <= result;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_beat  = out_beat_q;

	// Sleep types are only carried on a successful parse
	a_types_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && (dst_beat.status != ST_OK)
		|-> (dst_beat.sleep_type_a == '0) && (dst_beat.sleep_type_b == '0))
		else $error("sleep types nonzero on a failing status");

	// Input stalls only when a byte is held and the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> valid_s1 && dst_valid && !dst_ready)
		else $error("input stalled without a blocked result");

	// A waiting result must not be overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |-> !advance)
		else $error("parser advanced while a result was blocked");

endmodule
